### hdl/gwpr_pkg.sv
// ----------------------------------------------------------------------------
// Grid wavefront path router package
// Shared types, request and cell codes, sequencer states and neighbor tables.
// ----------------------------------------------------------------------------
package gwpr_pkg;

  localparam int unsigned COORD_W    = 7;
  localparam int unsigned CFG_W      = 6;
  localparam int unsigned PIDX_W     = 10;
  localparam int unsigned LEN_W      = 11;
  localparam int unsigned PATH_DEPTH = 1024;

  // Request codes.
  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_SOLVE = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  // Cell kinds in the map.
  localparam logic [1:0] KIND_FREE   = 2'd0;
  localparam logic [1:0] KIND_WALL   = 2'd1;
  localparam logic [1:0] KIND_SOURCE = 2'd2;
  localparam logic [1:0] KIND_TARGET = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  // Neighbor order: up, left, down, right, down-right, down-left, up-right, up-left.
  localparam logic [1:0] NB_DR [8] = '{2'b11, 2'b00, 2'b01, 2'b00,
                                       2'b01, 2'b01, 2'b11, 2'b11};
  localparam logic [1:0] NB_DC [8] = '{2'b00, 2'b11, 2'b00, 2'b01,
                                       2'b01, 2'b11, 2'b01, 2'b11};

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_NB_RD,
    ST_NB_CHK,
    ST_TR_RD,
    ST_TR_CHK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [4:0]        cell_row;
    logic [4:0]        cell_col;
    logic [1:0]        cell_kind;
    logic [PIDX_W-1:0] path_index;
  } req_t;

  typedef struct packed {
    logic             found;
    logic [LEN_W-1:0] path_length;
    logic [4:0]       point_row;
    logic [4:0]       point_col;
    logic             point_valid;
  } res_t;

  // Path store write and clear control.
  typedef struct packed {
    logic              clr;
    logic              we;
    logic [PIDX_W-1:0] idx;
    logic [4:0]        row;
    logic [4:0]        col;
  } pw_t;

  // Path point read result.
  typedef struct packed {
    logic       strobe;
    logic       set;
    logic [4:0] row;
    logic [4:0] col;
  } pt_t;

endpackage

### hdl/gwpr_nbr_unit.sv
// ----------------------------------------------------------------------------
// Neighbor unit
// Steps a cell by one of eight offsets, checks the area in use, forms address.
// ----------------------------------------------------------------------------
module gwpr_nbr_unit #(
  parameter int unsigned GRID_COLS = 32,
  parameter int unsigned AW        = 10
) (
  input  logic [gwpr_pkg::COORD_W-1:0] cur_r_i,
  input  logic [gwpr_pkg::COORD_W-1:0] cur_c_i,
  input  logic [2:0]                   k_i,
  input  logic [gwpr_pkg::COORD_W-1:0] rows_i,
  input  logic [gwpr_pkg::COORD_W-1:0] cols_i,
  output logic                         in_area_o,
  output logic [gwpr_pkg::COORD_W-1:0] nb_r_o,
  output logic [gwpr_pkg::COORD_W-1:0] nb_c_o,
  output logic [AW-1:0]                addr_o
);
  import gwpr_pkg::*;

  logic [COORD_W:0] r_ext;
  logic [COORD_W:0] c_ext;
  logic [31:0]      addr32;

  // Add the sign-extended offsets; the top bit flags a step off the low edge.
  always_comb begin
    r_ext     = {1'b0, cur_r_i} + {{(COORD_W-1){NB_DR[k_i][1]}}, NB_DR[k_i]};
    c_ext     = {1'b0, cur_c_i} + {{(COORD_W-1){NB_DC[k_i][1]}}, NB_DC[k_i]};
    nb_r_o    = r_ext[COORD_W-1:0];
    nb_c_o    = c_ext[COORD_W-1:0];
    in_area_o = !r_ext[COORD_W] && !c_ext[COORD_W] &&
                (nb_r_o < rows_i) && (nb_c_o < cols_i);
    addr32    = 32'(nb_r_o) * GRID_COLS + 32'(nb_c_o);
    addr_o    = addr32[AW-1:0];
  end

endmodule

### hdl/gwpr_path_store.sv
// ----------------------------------------------------------------------------
// Path store
// Holds traced path points and the index range written by the last solve.
// ----------------------------------------------------------------------------
module gwpr_path_store (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  gwpr_pkg::pw_t               pw_i,
  input  logic                        rd_en_i,
  input  logic [gwpr_pkg::PIDX_W-1:0] rd_idx_i,
  output gwpr_pkg::pt_t               pt_o
);
  import gwpr_pkg::*;

  logic [9:0]        mem [PATH_DEPTH];
  logic [9:0]        rd_data_q;
  logic [PIDX_W-1:0] ridx_q;
  logic [PIDX_W-1:0] lo_q;
  logic [PIDX_W-1:0] hi_q;
  logic              any_q;
  logic              pend_q;
  logic              set;

  // Point memory with registered read.
  always_ff @(posedge clk_i) begin
    if (pw_i.we) begin
      mem[pw_i.idx] <= {pw_i.row, pw_i.col};
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_idx_i];
      ridx_q    <= rd_idx_i;
    end
  end

  // The trace writes falling indexes, so the set entries form one range.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      any_q  <= 1'b0;
      pend_q <= 1'b0;
      lo_q   <= '0;
      hi_q   <= '0;
    end else begin
      pend_q <= rd_en_i;
      if (pw_i.clr) begin
        any_q <= 1'b0;
      end else if (pw_i.we) begin
        lo_q  <= pw_i.idx;
        any_q <= 1'b1;
        if (!any_q) begin
          hi_q <= pw_i.idx;
        end
      end
    end
  end

  assign set = any_q && (ridx_q >= lo_q) && (ridx_q <= hi_q);

  always_comb begin
    pt_o.strobe = pend_q;
    pt_o.set    = set;
    pt_o.row    = set ? rd_data_q[9:5] : 5'd0;
    pt_o.col    = set ? rd_data_q[4:0] : 5'd0;
  end

endmodule

### hdl/grid_wavefront_path_router_unit.sv
// ----------------------------------------------------------------------------
// Grid wavefront path router
// 8-connected Lee maze router with map writes, solve and path point reads.
// ----------------------------------------------------------------------------
// Usage: an item is taken when start_i is high and busy_o is low. A map write
// gives no result. A path read gives its result on res_o with res_strobe_o
// high in the cycle after it is taken; reads can follow one per cycle. A solve
// copies the map into the level grid cell by cell, then sweeps the area in use
// once per wave level: it reads and checks the level of each cell and, for each
// cell on the current level, reads and checks each neighbor inside the area and
// skips each neighbor outside it. The trace back reads and checks each neighbor
// it looks at inside the area and skips those outside it. The solve result shows
// for one cycle and busy_o falls in the cycle after it. The single read port of
// the level memory sets the pace of this. After reset the block clears every map
// cell with busy_o high; configuration writes on cfg_we_i are taken at any time
// but should only change while the block is idle. Results are only strobed; the
// receiver must take each one in its cycle.
// ----------------------------------------------------------------------------
module grid_wavefront_path_router_unit #(
  parameter int unsigned GRID_ROWS = 32,
  parameter int unsigned GRID_COLS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  gwpr_pkg::req_t             in_i,
  output logic                       res_strobe_o,
  output gwpr_pkg::res_t             res_o,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [gwpr_pkg::CFG_W-1:0] cfg_wdata_i
);
  import gwpr_pkg::*;

  localparam int unsigned CELLS = GRID_ROWS * GRID_COLS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned LW    = $clog2(CELLS) + 2;
  localparam logic [LW-1:0] LV_FREE   = {LW{1'b1}};
  localparam logic [LW-1:0] LV_TARGET = LV_FREE - LW'(1);
  localparam logic [LW-1:0] LV_WALL   = LV_FREE - LW'(2);
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);

  state_e             state_q, state_d;
  logic [AW-1:0]      idx_q, idx_d;
  logic [COORD_W-1:0] cur_r_q, cur_r_d;
  logic [COORD_W-1:0] cur_c_q, cur_c_d;
  logic [2:0]         k_q, k_d;
  logic [LW-1:0]      num_q, num_d;
  logic               any_q, any_d;
  logic               found_q, found_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic [4:0]         ep_r_q, ep_r_d;
  logic [4:0]         ep_c_q, ep_c_d;
  logic [CFG_W-1:0]   rows_q;
  logic [CFG_W-1:0]   cols_q;

  logic [COORD_W-1:0] rows_use;
  logic [COORD_W-1:0] cols_use;
  logic [31:0]        cur_addr32;
  logic [AW-1:0]      cur_addr;
  logic [31:0]        wr_addr32;
  logic [31:0]        num32;
  logic               accept;
  logic               adv;
  logic               put_en;
  logic [LW-1:0]      put_lvl;
  logic [31:0]        put_idx32;
  logic [4:0]         put_r;
  logic [4:0]         put_c;

  logic               nb_in;
  logic [COORD_W-1:0] nb_r;
  logic [COORD_W-1:0] nb_c;
  logic [AW-1:0]      nb_addr;

  logic [1:0]         cm_mem [CELLS];
  logic [1:0]         cm_rdata_q;
  logic               cm_rd_en;
  logic               cm_we;
  logic [AW-1:0]      cm_waddr;
  logic [1:0]         cm_wdata;

  logic [LW-1:0]      lv_mem [CELLS];
  logic [LW-1:0]      lv_rdata_q;
  logic               lv_rd_en;
  logic [AW-1:0]      lv_raddr;
  logic               lv_we;
  logic [AW-1:0]      lv_waddr;
  logic [LW-1:0]      lv_wdata;

  pw_t                pw;
  pt_t                pt;

  // Level code for a map kind.
  function automatic logic [LW-1:0] kind_level(input logic [1:0] kind);
    logic [LW-1:0] lv;
    unique case (kind)
      KIND_FREE:   lv = LV_FREE;
      KIND_WALL:   lv = LV_WALL;
      KIND_SOURCE: lv = '0;
      KIND_TARGET: lv = LV_TARGET;
      default:     lv = LV_FREE;
    endcase
    return lv;
  endfunction

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= CFG_W'(30);
      cols_q <= CFG_W'(30);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ROWS: rows_q <= cfg_wdata_i;
        CFG_COLS: cols_q <= cfg_wdata_i;
        default:  rows_q <= rows_q;
      endcase
    end
  end

  // Area in use, with zero read as one and large values held to the grid.
  always_comb begin
    if (rows_q == '0) begin
      rows_use = COORD_W'(1);
    end else if (32'(rows_q) > GRID_ROWS) begin
      rows_use = COORD_W'(GRID_ROWS);
    end else begin
      rows_use = COORD_W'(rows_q);
    end
    if (cols_q == '0) begin
      cols_use = COORD_W'(1);
    end else if (32'(cols_q) > GRID_COLS) begin
      cols_use = COORD_W'(GRID_COLS);
    end else begin
      cols_use = COORD_W'(cols_q);
    end
  end

  gwpr_nbr_unit #(
    .GRID_COLS (GRID_COLS),
    .AW        (AW)
  ) u_nbr (
    .cur_r_i   (cur_r_q),
    .cur_c_i   (cur_c_q),
    .k_i       (k_q),
    .rows_i    (rows_use),
    .cols_i    (cols_use),
    .in_area_o (nb_in),
    .nb_r_o    (nb_r),
    .nb_c_o    (nb_c),
    .addr_o    (nb_addr)
  );

  assign cur_addr32 = 32'(cur_r_q) * GRID_COLS + 32'(cur_c_q);
  assign cur_addr   = cur_addr32[AW-1:0];
  assign wr_addr32  = 32'(in_i.cell_row) * GRID_COLS + 32'(in_i.cell_col);
  assign num32      = 32'(num_q);
  assign accept     = start_i && !busy_o;

  // Map memory.
  always_ff @(posedge clk_i) begin
    if (cm_we) begin
      cm_mem[cm_waddr] <= cm_wdata;
    end
    if (cm_rd_en) begin
      cm_rdata_q <= cm_mem[idx_q];
    end
  end

  // Level memory.
  always_ff @(posedge clk_i) begin
    if (lv_we) begin
      lv_mem[lv_waddr] <= lv_wdata;
    end
    if (lv_rd_en) begin
      lv_rdata_q <= lv_mem[lv_raddr];
    end
  end

  // Sequencer registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      idx_q   <= '0;
      cur_r_q <= '0;
      cur_c_q <= '0;
      k_q     <= '0;
      num_q   <= '0;
      any_q   <= 1'b0;
      found_q <= 1'b0;
      len_q   <= '0;
      ep_r_q  <= '0;
      ep_c_q  <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cur_r_q <= cur_r_d;
      cur_c_q <= cur_c_d;
      k_q     <= k_d;
      num_q   <= num_d;
      any_q   <= any_d;
      found_q <= found_d;
      len_q   <= len_d;
      ep_r_q  <= ep_r_d;
      ep_c_q  <= ep_c_d;
    end
  end

  // Next state: map clear, map writes, copy, wave sweeps and trace back.
  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    cur_r_d  = cur_r_q;
    cur_c_d  = cur_c_q;
    k_d      = k_q;
    num_d    = num_q;
    any_d    = any_q;
    found_d  = found_q;
    len_d    = len_q;
    ep_r_d   = ep_r_q;
    ep_c_d   = ep_c_q;
    adv      = 1'b0;
    put_en   = 1'b0;
    put_lvl  = num_q;
    put_r    = ep_r_q;
    put_c    = ep_c_q;
    cm_rd_en = 1'b0;
    cm_we    = 1'b0;
    cm_waddr = idx_q;
    cm_wdata = KIND_FREE;
    lv_rd_en = 1'b0;
    lv_raddr = cur_addr;
    lv_we    = 1'b0;
    lv_waddr = idx_q;
    lv_wdata = LV_FREE;
    pw.clr   = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        cm_we = 1'b1;
        if (idx_q == LAST_CELL) begin
          idx_d   = '0;
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          if (in_i.req_type == REQ_WRITE) begin
            if ((32'(in_i.cell_row) < GRID_ROWS) && (32'(in_i.cell_col) < GRID_COLS)) begin
              cm_we    = 1'b1;
              cm_waddr = wr_addr32[AW-1:0];
              cm_wdata = in_i.cell_kind;
            end
          end else if (in_i.req_type == REQ_SOLVE) begin
            ep_r_d  = in_i.cell_row;
            ep_c_d  = in_i.cell_col;
            idx_d   = '0;
            pw.clr  = 1'b1;
            state_d = ST_COPY_RD;
          end
        end
      end
      ST_COPY_RD: begin
        cm_rd_en = 1'b1;
        state_d  = ST_COPY_WR;
      end
      ST_COPY_WR: begin
        lv_we    = 1'b1;
        lv_wdata = kind_level(cm_rdata_q);
        if (idx_q == LAST_CELL) begin
          idx_d   = '0;
          cur_r_d = '0;
          cur_c_d = '0;
          num_d   = '0;
          any_d   = 1'b0;
          state_d = ST_SCAN_RD;
        end else begin
          idx_d   = idx_q + AW'(1);
          state_d = ST_COPY_RD;
        end
      end
      ST_SCAN_RD: begin
        lv_rd_en = 1'b1;
        state_d  = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        if (lv_rdata_q == num_q) begin
          any_d   = 1'b1;
          k_d     = '0;
          state_d = ST_NB_RD;
        end else begin
          adv = 1'b1;
        end
      end
      ST_NB_RD: begin
        if (nb_in) begin
          lv_rd_en = 1'b1;
          lv_raddr = nb_addr;
          state_d  = ST_NB_CHK;
        end else if (k_q == 3'd7) begin
          adv = 1'b1;
        end else begin
          k_d = k_q + 3'd1;
        end
      end
      ST_NB_CHK: begin
        if (lv_rdata_q == LV_TARGET) begin
          // A target touches this level: report, and start the trace back unless the level is zero.
          found_d = 1'b1;
          len_d   = (num32 >= 32'd1023) ? LEN_W'(PATH_DEPTH) : LEN_W'(num32 + 32'd1);
          cur_r_d = COORD_W'(ep_r_q);
          cur_c_d = COORD_W'(ep_c_q);
          k_d     = '0;
          put_en  = 1'b1;
          state_d = (num_q == '0) ? ST_DONE : ST_TR_RD;
        end else begin
          if (lv_rdata_q == LV_FREE) begin
            lv_we    = 1'b1;
            lv_waddr = nb_addr;
            lv_wdata = num_q + LW'(1);
          end
          if (k_q == 3'd7) begin
            adv = 1'b1;
          end else begin
            k_d     = k_q + 3'd1;
            state_d = ST_NB_RD;
          end
        end
      end
      ST_TR_RD: begin
        if (nb_in) begin
          lv_rd_en = 1'b1;
          lv_raddr = nb_addr;
          state_d  = ST_TR_CHK;
        end else if (k_q == 3'd7) begin
          state_d = ST_DONE;
        end else begin
          k_d = k_q + 3'd1;
        end
      end
      ST_TR_CHK: begin
        if (lv_rdata_q == num_q) begin
          cur_r_d = nb_r;
          cur_c_d = nb_c;
          put_en  = 1'b1;
          put_lvl = num_q - LW'(1);
          put_r   = nb_r[4:0];
          put_c   = nb_c[4:0];
          num_d   = num_q - LW'(1);
          k_d     = '0;
          state_d = (num_q == LW'(1)) ? ST_DONE : ST_TR_RD;
        end else if (k_q == 3'd7) begin
          state_d = ST_DONE;
        end else begin
          k_d     = k_q + 3'd1;
          state_d = ST_TR_RD;
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Step to the next cell of the sweep, or close the sweep.
    if (adv) begin
      state_d = ST_SCAN_RD;
      if ((cur_c_q + COORD_W'(1)) < cols_use) begin
        cur_c_d = cur_c_q + COORD_W'(1);
      end else begin
        cur_c_d = '0;
        if ((cur_r_q + COORD_W'(1)) < rows_use) begin
          cur_r_d = cur_r_q + COORD_W'(1);
        end else if (!any_q) begin
          found_d = 1'b0;
          len_d   = '0;
          state_d = ST_DONE;
        end else begin
          cur_r_d = '0;
          num_d   = num_q + LW'(1);
          any_d   = 1'b0;
        end
      end
    end

    put_idx32 = 32'(put_lvl);
    pw.we     = put_en && (put_idx32 < PATH_DEPTH);
    pw.idx    = put_idx32[PIDX_W-1:0];
    pw.row    = put_r;
    pw.col    = put_c;
  end

  gwpr_path_store u_path (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pw_i     (pw),
    .rd_en_i  (accept && (in_i.req_type == REQ_READ)),
    .rd_idx_i (in_i.path_index),
    .pt_o     (pt)
  );

  // Result ports.
  assign busy_o       = (state_q != ST_IDLE);
  assign res_strobe_o = (state_q == ST_DONE) || pt.strobe;

  always_comb begin
    if (state_q == ST_DONE) begin
      res_o.found       = found_q;
      res_o.path_length = len_q;
      res_o.point_row   = 5'd0;
      res_o.point_col   = 5'd0;
      res_o.point_valid = 1'b0;
    end else begin
      res_o.found       = 1'b0;
      res_o.path_length = '0;
      res_o.point_row   = pt.row;
      res_o.point_col   = pt.col;
      res_o.point_valid = pt.set;
    end
  end

  // A solve result and a read result never fall in the same cycle.
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pt.strobe && (state_q == ST_DONE)))
    else $error("solve and read results collide");

  // The solve result lasts one cycle.
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |=> (state_q == ST_IDLE))
    else $error("solve result held too long");

  // A result without a found target carries no path length.
  a_len_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && !res_o.found) |-> (res_o.path_length == '0))
    else $error("path length without a found target");

  // A read result follows an accepted read item.
  a_read_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_i.req_type == REQ_READ)) |=> pt.strobe)
    else $error("read item gave no result");

endmodule

### tb/sv/grid_wavefront_path_router_unit_tb.sv
// ----------------------------------------------------------------------------
// Grid wavefront path router testbench
// Loads maps, runs solves and reads back path points. Every item that the
// block takes is fed to a behavioral router model in this file, and each
// strobed result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module grid_wavefront_path_router_unit_tb;
  import gwpr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NROWS     = 32;
  localparam int NCOLS     = 32;
  localparam int IDLE_MAX  = 400000;
  localparam int EPISODES  = 55;

  logic             clk_i;
  logic             rst_ni;
  logic             start_i;
  logic             busy_o;
  req_t             in_i;
  logic             res_strobe_o;
  res_t             res_o;
  logic             cfg_we_i;
  logic             cfg_idx_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  grid_wavefront_path_router_unit #(.GRID_ROWS(NROWS), .GRID_COLS(NCOLS)) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .in_i         (in_i),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // Router model state.
  logic [1:0]       map_kind [NROWS*NCOLS];
  int               wave_lvl [NROWS*NCOLS];
  logic [4:0]       pt_row   [PATH_DEPTH];
  logic [4:0]       pt_col   [PATH_DEPTH];
  bit               pt_set   [PATH_DEPTH];
  int               route_len;
  logic [CFG_W-1:0] area_rows;
  logic [CFG_W-1:0] area_cols;

  // Level markers in the model's wave grid.
  localparam int LVL_FREE   = -1;
  localparam int LVL_TARGET = -2;
  localparam int LVL_WALL   = -3;

  // Neighbor order: up, left, down, right, down-right, down-left, up-right, up-left.
  int step_dr [8] = '{-1, 0, 1, 0, 1, 1, -1, -1};
  int step_dc [8] = '{0, -1, 0, 1, 1, -1, 1, -1};

  res_t route_results_q [$];
  int   mismatches;
  int   idle_cycles;
  bit   no_idle;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int clamp_dim(logic [CFG_W-1:0] v, int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return int'(v);
  endfunction

  // Grows the wave level by level; gives the level that touched a target or -1.
  function automatic int spread_wave(int rows, int cols);
    int num;
    bit any;
    int ni;
    int nj;
    num = 0;
    forever begin
      any = 1'b0;
      for (int i = 0; i < rows; i++) begin
        for (int j = 0; j < cols; j++) begin
          if (wave_lvl[i*NCOLS+j] == num) begin
            any = 1'b1;
            for (int k = 0; k < 8; k++) begin
              ni = i + step_dr[k];
              nj = j + step_dc[k];
              if (ni >= 0 && nj >= 0 && ni < rows && nj < cols) begin
                if (wave_lvl[ni*NCOLS+nj] == LVL_TARGET) return num;
                if (wave_lvl[ni*NCOLS+nj] == LVL_FREE) wave_lvl[ni*NCOLS+nj] = num + 1;
              end
            end
          end
        end
      end
      if (!any) return -1;
      num++;
    end
  endfunction

  function automatic void store_point(int idx, int r, int c);
    if (idx < 0 || idx >= PATH_DEPTH) return;
    pt_row[idx] = r[4:0];
    pt_col[idx] = c[4:0];
    pt_set[idx] = 1'b1;
  endfunction

  // Walks back from the endpoint toward the source, one level per step.
  function automatic void trace_back(int er, int ec, int top, int rows, int cols);
    int r;
    int c;
    int ni;
    int nj;
    bit hit;
    r = er;
    c = ec;
    store_point(top, er, ec);
    for (int s = top; s >= 1; s--) begin
      hit = 1'b0;
      for (int k = 0; k < 8 && !hit; k++) begin
        ni = r + step_dr[k];
        nj = c + step_dc[k];
        if (ni >= 0 && nj >= 0 && ni < rows && nj < cols &&
            wave_lvl[ni*NCOLS+nj] == s) begin
          r = ni;
          c = nj;
          hit = 1'b1;
        end
      end
      if (!hit) return;
      store_point(s - 1, r, c);
    end
  endfunction

  // Applies one accepted item to the model; has_res tells if a result follows.
  function automatic res_t route_predict(req_t it, output bit has_res);
    res_t res;
    int rows;
    int cols;
    int top;
    res = '0;
    has_res = 1'b0;
    case (it.req_type)
      REQ_WRITE: begin
        map_kind[it.cell_row*NCOLS+it.cell_col] = it.cell_kind;
      end
      REQ_SOLVE: begin
        rows = clamp_dim(area_rows, NROWS);
        cols = clamp_dim(area_cols, NCOLS);
        for (int i = 0; i < NROWS*NCOLS; i++) begin
          case (map_kind[i])
            KIND_FREE:   wave_lvl[i] = LVL_FREE;
            KIND_WALL:   wave_lvl[i] = LVL_WALL;
            KIND_SOURCE: wave_lvl[i] = 0;
            default:     wave_lvl[i] = LVL_TARGET;
          endcase
        end
        for (int i = 0; i < PATH_DEPTH; i++) pt_set[i] = 1'b0;
        top = spread_wave(rows, cols);
        route_len = 0;
        if (top >= 0) begin
          route_len = (top + 1 > PATH_DEPTH) ? PATH_DEPTH : top + 1;
          trace_back(it.cell_row, it.cell_col, top, rows, cols);
        end
        res.found = (top >= 0);
        res.path_length = route_len[LEN_W-1:0];
        has_res = 1'b1;
      end
      REQ_READ: begin
        if (pt_set[it.path_index]) begin
          res.point_row = pt_row[it.path_index];
          res.point_col = pt_col[it.path_index];
          res.point_valid = 1'b1;
        end
        has_res = 1'b1;
      end
      default: ;
    endcase
    return res;
  endfunction

  // Sends one item and predicts its result once it is taken. Start stays high
  // when no gap follows, so callers end a phase with drain_results.
  task automatic send_item(req_t it);
    res_t exp_res;
    bit has_res;
    int gap;
    in_i <= it;
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    exp_res = route_predict(it, has_res);
    if (has_res) route_results_q.push_back(exp_res);
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (route_results_q.size() != 0 || busy_o) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [CFG_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_ROWS) area_rows = val;
    else area_cols = val;
  endtask

  task automatic set_area(logic [CFG_W-1:0] r, logic [CFG_W-1:0] c);
    write_cfg(CFG_ROWS, r);
    write_cfg(CFG_COLS, c);
  endtask

  function automatic req_t make_req(logic [1:0] kind_of_req, int r, int c, logic [1:0] k,
                                    int idx);
    req_t it;
    it.req_type = kind_of_req;
    it.cell_row = r[4:0];
    it.cell_col = c[4:0];
    it.cell_kind = k;
    it.path_index = idx[PIDX_W-1:0];
    return it;
  endfunction

  task automatic put_cell(int r, int c, logic [1:0] k);
    send_item(make_req(REQ_WRITE, r, c, k, $urandom_range(0, 1023)));
  endtask

  task automatic solve_at(int r, int c);
    send_item(make_req(REQ_SOLVE, r, c, 2'($urandom_range(0, 3)), $urandom_range(0, 1023)));
  endtask

  task automatic read_point(int idx);
    send_item(make_req(REQ_READ, $urandom_range(0, 31), $urandom_range(0, 31),
                       2'($urandom_range(0, 3)), idx));
  endtask

  // Reads every stored point of the last route and the entry past it.
  task automatic read_route();
    int n;
    n = route_len;
    for (int i = 0; i <= n && i < PATH_DEPTH; i++) read_point(i);
  endtask

  // Default area leaves the far corner out, so a target there is unreachable.
  task automatic test_default_area();
    put_cell(0, 0, KIND_SOURCE);
    put_cell(31, 31, KIND_TARGET);
    solve_at(31, 31);
    read_point(0);
    read_point(1023);
    drain_results();
  endtask

  // An oversized row register clamps to the full grid: a long diagonal route.
  task automatic test_full_grid();
    set_area(6'd63, 6'd32);
    solve_at(31, 31);
    read_route();
    solve_at(31, 0);
    read_route();
    drain_results();
  endtask

  // Zero counts as one: a 1x1 area holds only the source; a 1x2 area then adds a target.
  task automatic test_zero_area();
    set_area(6'd0, 6'd0);
    solve_at(0, 0);
    read_point(0);
    drain_results();
    set_area(6'd1, 6'd2);
    put_cell(0, 1, KIND_TARGET);
    solve_at(0, 1);
    read_point(0);
    read_point(1);
    drain_results();
  endtask

  // No source or a walled-in source gives an empty route, and ignored requests give nothing.
  task automatic test_no_source_and_ignored();
    set_area(6'd4, 6'd4);
    put_cell(0, 0, KIND_FREE);
    put_cell(31, 31, KIND_FREE);
    put_cell(3, 3, KIND_TARGET);
    send_item(make_req(REQ_NONE, 31, 31, 2'd3, 1023));
    solve_at(3, 3);
    read_point(0);
    put_cell(0, 0, KIND_SOURCE);
    put_cell(1, 1, KIND_WALL);
    solve_at(2, 0);
    read_route();
    put_cell(0, 1, KIND_WALL);
    put_cell(1, 0, KIND_WALL);
    solve_at(3, 3);
    read_point(0);
    drain_results();
  endtask

  // Random mazes in small areas, with solve and read-back of the route.
  task automatic test_random_mazes();
    int rr;
    int cc;
    int er;
    int ec;
    int nsrc;
    int ntgt;
    logic [CFG_W-1:0] rv;
    logic [CFG_W-1:0] cv;
    for (int e = 0; e < EPISODES; e++) begin
      no_idle = ($urandom_range(0, 3) == 0);
      rv = 6'($urandom_range(1, 7));
      cv = 6'($urandom_range(1, 7));
      if ($urandom_range(0, 9) == 0) rv = $urandom_range(0, 1) ? 6'd0 : 6'($urandom_range(33, 63));
      if ($urandom_range(0, 9) == 0) cv = $urandom_range(0, 1) ? 6'd0 : 6'($urandom_range(33, 63));
      set_area(rv, cv);
      rr = (clamp_dim(rv, NROWS) > 7) ? 7 : clamp_dim(rv, NROWS);
      cc = (clamp_dim(cv, NCOLS) > 7) ? 7 : clamp_dim(cv, NCOLS);
      for (int i = 0; i < rr; i++) begin
        for (int j = 0; j < cc; j++) begin
          if ($urandom_range(0, 3) != 0)
            put_cell(i, j, ($urandom_range(0, 3) == 0) ? KIND_WALL : KIND_FREE);
        end
      end
      nsrc = $urandom_range(1, 2);
      ntgt = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 2);
      er = $urandom_range(0, 31);
      ec = $urandom_range(0, 31);
      for (int s = 0; s < nsrc; s++) put_cell($urandom_range(0, rr-1), $urandom_range(0, cc-1),
                                              KIND_SOURCE);
      for (int t = 0; t < ntgt; t++) begin
        er = $urandom_range(0, rr-1);
        ec = $urandom_range(0, cc-1);
        put_cell(er, ec, KIND_TARGET);
      end
      // Noise: an ignored request and a stray write anywhere in the grid.
      send_item(make_req(REQ_NONE, $urandom_range(0, 31), $urandom_range(0, 31),
                         2'($urandom_range(0, 3)), $urandom_range(0, 1023)));
      put_cell($urandom_range(0, 31), $urandom_range(0, 31), 2'($urandom_range(0, 3)));
      if ($urandom_range(0, 4) == 0) begin
        er = $urandom_range(0, 31);
        ec = $urandom_range(0, 31);
      end
      solve_at(er, ec);
      read_route();
      repeat (3) read_point($urandom_range(0, 1023));
      drain_results();
    end
    no_idle = 1'b0;
  endtask

  // Result checker.
  always @(posedge clk_i) begin
    res_t exp_res;
    if (rst_ni && res_strobe_o) begin
      if (route_results_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", res_o);
      end else begin
        exp_res = route_results_q.pop_front();
        if (res_o !== exp_res) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %p, got %p", exp_res, res_o);
        end
      end
    end
  end

  // Watchdog on cycles with no item taken and no result.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || res_strobe_o) idle_cycles <= 0;
    else if (idle_cycles >= IDLE_MAX) begin
      $display("[FAIL] regression broken");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    rst_ni = 1'b0;
    start_i = 1'b0;
    in_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_ROWS;
    cfg_wdata_i = '0;
    mismatches = 0;
    idle_cycles = 0;
    no_idle = 1'b0;
    route_len = 0;
    area_rows = 6'd30;
    area_cols = 6'd30;
    for (int i = 0; i < NROWS*NCOLS; i++) map_kind[i] = KIND_FREE;
    for (int i = 0; i < PATH_DEPTH; i++) pt_set[i] = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_area();
    test_full_grid();
    test_zero_area();
    test_no_source_and_ignored();
    test_random_mazes();
    drain_results();
    repeat (20) @(posedge clk_i);

    if (mismatches == 0 && route_results_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
